/* design/rpss_pkg.sv */
// rpss_pkg: shared constants and byte classifiers for the regex pattern syntax screen
// no dependencies; used by the top level and the input channel interface
package rpss_pkg;

    localparam int unsigned MAX_GROUP_DEPTH_DEF = 255;
    localparam int unsigned BYTE_W              = 8;

    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_LOW_C  = 8'h63;
    localparam logic [BYTE_W-1:0] CH_LOW_P  = 8'h70;
    localparam logic [BYTE_W-1:0] CH_UP_P   = 8'h50;
    localparam logic [BYTE_W-1:0] CH_LOW_I  = 8'h69;
    localparam logic [BYTE_W-1:0] CH_LOW_M  = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_LOW_S  = 8'h73;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    // escape letters that stay legal: bBfnrtvxdDsSwWuk
    function automatic logic is_allowed_escape(input logic [BYTE_W-1:0] b);
        logic r;
        unique case (b)
            8'h62, 8'h42, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76, 8'h78,
            8'h64, 8'h44, 8'h73, 8'h53, 8'h77, 8'h57, 8'h75, 8'h6B: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_modifier(input logic [BYTE_W-1:0] b);
        return (b == CH_LOW_I) || (b == CH_LOW_M) || (b == CH_LOW_S) || (b == CH_DASH);
    endfunction

endpackage

/* design/rpss_in_if.sv */
// rpss_in_if: input channel carrying one pattern byte per transfer
// depends on rpss_pkg for the byte width
interface rpss_in_if import rpss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pattern_byte;
    logic              has_byte;
    logic              last;

    modport source (output valid, output pattern_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input pattern_byte, input has_byte, input last,
                    output ready);
endinterface

/* design/rpss_out_if.sv */
// rpss_out_if: result channel carrying one verdict per pattern
// no dependencies
interface rpss_out_if;
    logic valid;
    logic ready;
    logic pattern_ok;
    logic depth_overflow;

    modport source (output valid, output pattern_ok, output depth_overflow, input ready);
    modport sink   (input valid, input pattern_ok, input depth_overflow, output ready);
endinterface

/* design/regex_pattern_syntax_screen.sv */
// Regex pattern syntax screen. Takes a pattern one byte per transfer on i_in and gives
// one verdict (pattern_ok, depth_overflow) on o_out for the transfer marked last. A new
// item is taken every cycle unless input stalls; one input register feeds the scan state
// update and the result register. A verdict enters the result register as its last item
// leaves the input register. Input stalls only when a verdict waits in the result register
// and the next final item needs it. Group depth is bounded by MAX_GROUP_DEPTH.
// depends on rpss_pkg, rpss_in_if, rpss_out_if
module regex_pattern_syntax_screen import rpss_pkg::*; #(
    parameter int unsigned MAX_GROUP_DEPTH = MAX_GROUP_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpss_in_if.sink     i_in,
    rpss_out_if.source  o_out
);

    localparam int unsigned DEPTH_W = $clog2(MAX_GROUP_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_GROUP_DEPTH);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CTRL,
        MODE_PBRACE,
        MODE_PFIRST,
        MODE_PBODY
    } t_scan_mode;

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_has;
    logic              r_s1_last;

    // scan state
    t_scan_mode         r_mode, n_mode;
    logic               r_class, n_class;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [1:0]         r_stage, n_stage;
    logic [23:0]        r_recent, n_recent;
    logic [1:0]         r_seen, n_seen;
    logic               r_failed, n_failed;
    logic               r_ovf, n_ovf;

    // result register
    logic r_out_valid;
    logic r_out_ok;
    logic r_out_ovf;

    logic s1_adv;
    logic s1_fire;
    logic verdict_ok;

    assign s1_adv     = !r_s1_last || !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign i_in.ready = !r_s1_valid || s1_adv;

    assign o_out.valid          = r_out_valid;
    assign o_out.pattern_ok     = r_out_ok;
    assign o_out.depth_overflow = r_out_ovf;

    always_comb begin
        logic [BYTE_W-1:0] b;
        b        = r_s1_byte;
        n_mode   = r_mode;
        n_class  = r_class;
        n_depth  = r_depth;
        n_stage  = r_stage;
        n_recent = r_recent;
        n_seen   = r_seen;
        n_failed = r_failed;
        n_ovf    = r_ovf;
        if (r_s1_has && !r_failed) begin
            // raw "(?" plus modifier, followed by one more byte
            if (r_seen == 2'd3 && r_recent[23:16] == CH_LPAREN &&
                r_recent[15:8] == CH_QMARK && is_modifier(r_recent[7:0])) begin
                n_failed = 1'b1;
            end
            n_recent = {r_recent[15:0], b};
            if (r_seen != 2'd3) begin
                n_seen = r_seen + 2'd1;
            end
            n_stage = 2'd0;
            unique case (r_mode)
                MODE_ESC: begin
                    if (b == CH_LOW_C) begin
                        n_mode = MODE_CTRL;
                    end else if (b == CH_LOW_P || b == CH_UP_P) begin
                        n_mode = MODE_PBRACE;
                    end else begin
                        if (is_letter(b) && !is_allowed_escape(b)) n_failed = 1'b1;
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_CTRL: begin
                    if (!is_letter(b)) n_failed = 1'b1;
                    n_mode = MODE_NORMAL;
                end
                MODE_PBRACE: begin
                    if (b != CH_LBRACE) n_failed = 1'b1;
                    n_mode = MODE_PFIRST;
                end
                MODE_PFIRST: begin
                    if (b == CH_RBRACE) n_failed = 1'b1;
                    n_mode = MODE_PBODY;
                end
                MODE_PBODY: begin
                    if (b == CH_RBRACE) n_mode = MODE_NORMAL;
                end
                default: begin
                    if (r_stage == 2'd2 && (b == CH_UP_P || b == CH_HASH || is_modifier(b))) begin
                        n_failed = 1'b1;
                    end
                    priority if (b == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (b == CH_LBRACK && !r_class) begin
                        n_class = 1'b1;
                    end else if (b == CH_RBRACK && r_class) begin
                        n_class = 1'b0;
                    end else if (!r_class) begin
                        if (b == CH_LPAREN) begin
                            if (r_depth >= DEPTH_MAX) begin
                                n_ovf    = 1'b1;
                                n_failed = 1'b1;
                            end else begin
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                            n_stage = 2'd1;
                        end else if (b == CH_QMARK && r_stage == 2'd1) begin
                            n_stage = 2'd2;
                        end else if (b == CH_RPAREN) begin
                            if (r_depth == '0) n_failed = 1'b1;
                            else               n_depth  = r_depth - DEPTH_W'(1);
                        end
                    end else begin
                        // other bytes inside a class are literal
                    end
                end
            endcase
        end
        verdict_ok = !n_failed && n_mode == MODE_NORMAL && !n_class && n_depth == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_s1_has    <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_NORMAL;
            r_class     <= 1'b0;
            r_depth     <= '0;
            r_stage     <= 2'd0;
            r_recent    <= '0;
            r_seen      <= 2'd0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
                r_s1_byte  <= i_in.pattern_byte;
                r_s1_has   <= i_in.has_byte;
                r_s1_last  <= i_in.last;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (o_out.valid && o_out.ready && !(s1_fire && r_s1_last)) begin
                r_out_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1_last) begin
                    r_out_valid <= 1'b1;
                    r_out_ok    <= verdict_ok;
                    r_out_ovf   <= n_ovf;
                    // back to reset values for the next pattern
                    r_mode      <= MODE_NORMAL;
                    r_class     <= 1'b0;
                    r_depth     <= '0;
                    r_stage     <= 2'd0;
                    r_recent    <= '0;
                    r_seen      <= 2'd0;
                    r_failed    <= 1'b0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_mode      <= n_mode;
                    r_class     <= n_class;
                    r_depth     <= n_depth;
                    r_stage     <= n_stage;
                    r_recent    <= n_recent;
                    r_seen      <= n_seen;
                    r_failed    <= n_failed;
                    r_ovf       <= n_ovf;
                end
            end
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("group depth above bound");

    a_ovf_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_failed)
        else $error("overflow without failure");

    a_ok_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ok |-> !r_out_ovf)
        else $error("passing verdict flagged overflow");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_last |=> r_depth == '0 && !r_failed && r_mode == MODE_NORMAL
                                 && r_out_valid)
        else $error("state not cleared after final transfer");

endmodule
